FILE: src/rmeu_pkg.sv
package rmeu_pkg;

    // Iteration count of every CORDIC; the angle table has 24 entries
    localparam int CORDIC_STEPS = 14;
    localparam int TAB_LEN      = 24;
    localparam int NUM_STEPS    = (CORDIC_STEPS < TAB_LEN) ? CORDIC_STEPS : TAB_LEN;

    localparam int ELEM_W = 16;
    localparam int SUM_W  = 32;
    localparam int ROOT_W = 16;
    localparam int REM_W  = 18;
    localparam int OPD_W  = 17;
    localparam int OP_W   = 27;
    localparam int ANG_W  = 28;
    localparam int OUT_W  = 16;
    localparam int LIM_W  = 15;

    localparam logic signed [ANG_W-1:0] HALF_PI_Q24 = ANG_W'(26353589);
    localparam logic signed [ANG_W-1:0] ANGLE_MAX   = ANG_W'(25736);
    localparam logic signed [ANG_W-1:0] ROUND_HALF  = ANG_W'(1024);

    localparam logic signed [ANG_W-1:0] ATAN_TAB [TAB_LEN] = '{
        ANG_W'(13176795), ANG_W'(7778716), ANG_W'(4110060), ANG_W'(2086331),
        ANG_W'(1047214),  ANG_W'(524117),  ANG_W'(262123),  ANG_W'(131069),
        ANG_W'(65536),    ANG_W'(32768),   ANG_W'(16384),   ANG_W'(8192),
        ANG_W'(4096),     ANG_W'(2048),    ANG_W'(1024),    ANG_W'(512),
        ANG_W'(256),      ANG_W'(128),     ANG_W'(64),      ANG_W'(32),
        ANG_W'(16),       ANG_W'(8),       ANG_W'(4),       ANG_W'(2)
    };

    // Last member sits in the lowest bits, so r00 lines up with tdata[15:0]
    typedef struct packed {
        logic signed [ELEM_W-1:0] r12;
        logic signed [ELEM_W-1:0] r11;
        logic signed [ELEM_W-1:0] r22;
        logic signed [ELEM_W-1:0] r21;
        logic signed [ELEM_W-1:0] r20;
        logic signed [ELEM_W-1:0] r10;
        logic signed [ELEM_W-1:0] r00;
    } t_mat;

    // One stage of the digit-by-digit square root
    typedef struct packed {
        logic              valid;
        logic [REM_W-1:0]  rem;
        logic [SUM_W-1:0]  rad;
        logic [ROOT_W-1:0] root;
        t_mat              m;
    } t_sq;

    typedef struct packed {
        logic signed [OP_W-1:0]  x;
        logic signed [OP_W-1:0]  y;
        logic signed [ANG_W-1:0] z;
        logic                    zero;
    } t_lane;

    // One stage of the three parallel CORDIC lanes
    typedef struct packed {
        logic  valid;
        logic  sing;
        t_lane lx;
        t_lane ly;
        t_lane lz;
    } t_cs;

    // One root bit: bring down two radicand bits, try root*4+1
    function automatic t_sq sq_step(t_sq a);
        logic [REM_W+1:0] shifted;
        logic [REM_W+1:0] trial;
        t_sq              b;
        shifted = {a.rem, a.rad[SUM_W-1 -: 2]};
        trial   = {2'b00, a.root, 2'b01};
        b       = a;
        b.rad   = {a.rad[SUM_W-3:0], 2'b00};
        if (shifted >= trial) begin
            b.rem  = REM_W'(shifted - trial);
            b.root = {a.root[ROOT_W-2:0], 1'b1};
        end else begin
            b.rem  = REM_W'(shifted);
            b.root = {a.root[ROOT_W-2:0], 1'b0};
        end
        return b;
    endfunction

    // Scale by 2^8 and fold the left half plane by a quarter turn
    function automatic t_lane cordic_init(logic signed [OPD_W-1:0] yin,
                                          logic signed [OPD_W-1:0] xin);
        logic signed [OP_W-1:0] xs;
        logic signed [OP_W-1:0] ys;
        t_lane                  l;
        xs     = {{(OP_W-OPD_W-8){xin[OPD_W-1]}}, xin, 8'b0};
        ys     = {{(OP_W-OPD_W-8){yin[OPD_W-1]}}, yin, 8'b0};
        l.zero = (xin == '0) && (yin == '0);
        l.x    = xs;
        l.y    = ys;
        l.z    = '0;
        if (xs < 0) begin
            if (ys >= 0) begin
                l.x = ys;
                l.y = -xs;
                l.z = HALF_PI_Q24;
            end else begin
                l.x = -ys;
                l.y = xs;
                l.z = -HALF_PI_Q24;
            end
        end
        return l;
    endfunction

    // Micro-rotation toward y = 0
    function automatic t_lane cordic_step(t_lane a, int i);
        logic signed [OP_W-1:0] dx;
        logic signed [OP_W-1:0] dy;
        t_lane                  b;
        dx = a.y >>> i;
        dy = a.x >>> i;
        b  = a;
        if (a.y < 0) begin
            b.x = a.x - dx;
            b.y = a.y + dy;
            b.z = a.z - ATAN_TAB[i];
        end else begin
            b.x = a.x + dx;
            b.y = a.y - dy;
            b.z = a.z + ATAN_TAB[i];
        end
        return b;
    endfunction

    // Round Q24 to Q3.13 (half up) and clamp
    function automatic logic [OUT_W-1:0] round_sat(t_lane l);
        logic signed [ANG_W-1:0] r;
        r = (l.z + ROUND_HALF) >>> 11;
        if (l.zero) begin
            r = '0;
        end else if (r > ANGLE_MAX) begin
            r = ANGLE_MAX;
        end else if (r < -ANGLE_MAX) begin
            r = -ANGLE_MAX;
        end
        return r[OUT_W-1:0];
    endfunction

endpackage

FILE: src/rotation_matrix_to_euler_unit.sv
// An input transfer passes the input register, square sum, 16 root stages,
// operand setup, one stage per CORDIC step and the output register.
// Throughput: one matrix per cycle; an output stall holds the whole pipeline
// in place. Reset clears all valid bits and sets the singular limit to 1.
module rotation_matrix_to_euler_unit (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_cfg_we,
    input  logic [14:0]  i_cfg_wdata,
    input  logic         i_s_axis_tvalid,
    output logic         o_s_axis_tready,
    // r00, r10, r20, r21, r22, r11, r12 (16 bits each, lowest first)
    input  logic [111:0] i_s_axis_tdata,
    output logic         o_m_axis_tvalid,
    input  logic         i_m_axis_tready,
    // angle_x, angle_y, angle_z (16 bits each, lowest first)
    output logic [47:0]  o_m_axis_tdata,
    // is_singular
    output logic [0:0]   o_m_axis_tuser
);

    localparam int SQ_N = rmeu_pkg::ROOT_W;
    localparam int CS_N = rmeu_pkg::NUM_STEPS;

    logic [rmeu_pkg::LIM_W-1:0] r_limit;
    logic                       r_in_valid;
    rmeu_pkg::t_mat             r_in_m;
    rmeu_pkg::t_sq              r_sq [SQ_N+1];
    rmeu_pkg::t_cs              r_cs [CS_N+1];
    logic                       r_out_valid;
    logic [47:0]                r_out_data;
    logic                       r_out_sing;

    rmeu_pkg::t_sq              n_sq0;
    rmeu_pkg::t_cs              n_cs0;
    logic                       w_adv;
    logic [rmeu_pkg::SUM_W-1:0] w_p0;
    logic [rmeu_pkg::SUM_W-1:0] w_p1;
    logic                       w_sing;
    logic signed [rmeu_pkg::OPD_W-1:0] w_neg_r20;
    logic signed [rmeu_pkg::OPD_W-1:0] w_neg_r12;

    // Advance every stage together unless the output is held
    assign w_adv           = !r_out_valid || i_m_axis_tready;
    assign o_s_axis_tready = w_adv;

    // Sum of squares into the root pipeline
    always_comb begin
        w_p0        = rmeu_pkg::SUM_W'(r_in_m.r00 * r_in_m.r00);
        w_p1        = rmeu_pkg::SUM_W'(r_in_m.r10 * r_in_m.r10);
        n_sq0.valid = r_in_valid;
        n_sq0.rem   = '0;
        n_sq0.root  = '0;
        n_sq0.rad   = w_p0 + w_p1;
        n_sq0.m     = r_in_m;
    end

    // Branch decision and CORDIC operand setup
    always_comb begin
        w_sing    = r_sq[SQ_N].root < {1'b0, r_limit};
        w_neg_r20 = -{r_sq[SQ_N].m.r20[15], r_sq[SQ_N].m.r20};
        w_neg_r12 = -{r_sq[SQ_N].m.r12[15], r_sq[SQ_N].m.r12};
        n_cs0.valid = r_sq[SQ_N].valid;
        n_cs0.sing  = w_sing;
        n_cs0.ly    = rmeu_pkg::cordic_init(w_neg_r20, {1'b0, r_sq[SQ_N].root});
        n_cs0.lz    = rmeu_pkg::cordic_init(
            {r_sq[SQ_N].m.r10[15], r_sq[SQ_N].m.r10},
            {r_sq[SQ_N].m.r00[15], r_sq[SQ_N].m.r00});
        if (w_sing) begin
            n_cs0.lx = rmeu_pkg::cordic_init(w_neg_r12,
                {r_sq[SQ_N].m.r11[15], r_sq[SQ_N].m.r11});
        end else begin
            n_cs0.lx = rmeu_pkg::cordic_init(
                {r_sq[SQ_N].m.r21[15], r_sq[SQ_N].m.r21},
                {r_sq[SQ_N].m.r22[15], r_sq[SQ_N].m.r22});
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit     <= rmeu_pkg::LIM_W'(1);
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            for (int k = 0; k <= SQ_N; k++) begin
                r_sq[k].valid <= 1'b0;
            end
            for (int k = 0; k <= CS_N; k++) begin
                r_cs[k].valid <= 1'b0;
            end
        end else begin
            if (i_cfg_we) begin
                r_limit <= i_cfg_wdata;
            end
            if (w_adv) begin
                // Capture the input transfer
                r_in_valid <= i_s_axis_tvalid;
                r_in_m     <= i_s_axis_tdata;
                // Root stages, one bit each
                r_sq[0] <= n_sq0;
                for (int k = 0; k < SQ_N; k++) begin
                    r_sq[k+1] <= rmeu_pkg::sq_step(r_sq[k]);
                end
                // CORDIC stages, one micro-rotation each
                r_cs[0] <= n_cs0;
                for (int k = 0; k < CS_N; k++) begin
                    r_cs[k+1].valid <= r_cs[k].valid;
                    r_cs[k+1].sing  <= r_cs[k].sing;
                    r_cs[k+1].lx    <= rmeu_pkg::cordic_step(r_cs[k].lx, k);
                    r_cs[k+1].ly    <= rmeu_pkg::cordic_step(r_cs[k].ly, k);
                    r_cs[k+1].lz    <= rmeu_pkg::cordic_step(r_cs[k].lz, k);
                end
                // Round, clamp and drop z on the singular branch
                r_out_valid <= r_cs[CS_N].valid;
                r_out_sing  <= r_cs[CS_N].sing;
                r_out_data[15:0]  <= rmeu_pkg::round_sat(r_cs[CS_N].lx);
                r_out_data[31:16] <= rmeu_pkg::round_sat(r_cs[CS_N].ly);
                r_out_data[47:32] <= r_cs[CS_N].sing ? 16'd0
                                   : rmeu_pkg::round_sat(r_cs[CS_N].lz);
            end
        end
    end

    assign o_m_axis_tvalid   = r_out_valid;
    assign o_m_axis_tdata    = r_out_data;
    assign o_m_axis_tuser[0] = r_out_sing;

    a_sing_z_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && o_m_axis_tuser[0]) |-> (o_m_axis_tdata[47:32] == 16'd0))
        else $error("singular result with nonzero z");

    a_x_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> ($signed(o_m_axis_tdata[15:0]) <= 16'sd25736 &&
                             $signed(o_m_axis_tdata[15:0]) >= -16'sd25736))
        else $error("angle_x out of range");

    a_y_half_plane: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> ($signed(o_m_axis_tdata[31:16]) <= 16'sd14300 &&
                             $signed(o_m_axis_tdata[31:16]) >= -16'sd14300))
        else $error("angle_y outside the right half plane");

    a_hold_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cs[CS_N].valid && !w_adv) |=> r_cs[CS_N].valid)
        else $error("pipeline item lost during stall");

endmodule
